### design/bmp_pkg.sv
// Package for the binomial coefficient block: field widths, prime constants,
// multiplier operation codes and the controller/datapath command and status structs.
// Depends on nothing; every other design file imports it.
package bmp_pkg;

    localparam int BMP_IN_W    = 16;
    localparam int BMP_RES_W   = 30;
    localparam int BMP_BOUND_W = 21;
    localparam int BMP_MAX_N   = 65535;

    // The prime modulus and its reciprocal reduction constant floor(2^60 / p).
    localparam logic [BMP_RES_W-1:0] BMP_PRIME    = 30'd1000000007;
    localparam logic [BMP_RES_W-1:0] BMP_PRIME_M2 = 30'd1000000005;
    localparam logic [30:0]          BMP_MU       = 31'd1152921496;

    // Operand selection for one modular multiply; the code travels with the
    // product and picks the register that takes the result.
    typedef enum logic [2:0] {
        MUL_NUM = 3'd0,
        MUL_DEN = 3'd1,
        MUL_ACC = 3'd2,
        MUL_SQR = 3'd3,
        MUL_FIN = 3'd4
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    k_step;
        logic    exp_init;
        logic    exp_shift;
        logic    mul_go;
        mul_op_t mul_op;
        logic    res_set;
        logic    res_one;
        logic    out_load;
    } bmp_cmd_t;

    typedef struct packed {
        logic out_of_bound;
        logic r_above_n;
        logic r_zero;
        logic k_last;
        logic exp_bit;
        logic exp_last;
        logic mul_busy;
    } bmp_status_t;

endpackage

### design/bmp_modmul.sv
// Five-stage pipelined modular multiplier for the prime 1000000007, reducing the
// product by multiplication with a precomputed reciprocal. Depends on bmp_pkg.
module bmp_modmul
    import bmp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  mul_op_t              op,
    input  logic [BMP_RES_W-1:0] a,
    input  logic [BMP_RES_W-1:0] b,
    output logic                 busy,
    output logic                 res_valid,
    output mul_op_t              res_op,
    output logic [BMP_RES_W-1:0] res
);

    localparam logic [31:0] Prime32  = {2'b00, BMP_PRIME};
    localparam logic [31:0] Prime2x  = {1'b0, BMP_PRIME, 1'b0};

    logic [4:0]    valid_reg;
    logic [4:0]    valid_next;
    mul_op_t       op_reg [5];

    logic [59:0]          prod_reg;
    logic [59:0]          prod_next;
    logic [61:0]          quot_reg;
    logic [61:0]          quot_next;
    logic [31:0]          xlo2_reg;
    logic [31:0]          xlo3_reg;
    logic [31:0]          qp_reg;
    logic [31:0]          qp_next;
    logic [31:0]          rem_reg;
    logic [31:0]          rem_next;
    logic [BMP_RES_W-1:0] res_reg;
    logic [BMP_RES_W-1:0] res_next;

    always_comb
    begin
        valid_next = {valid_reg[3:0], go};
        prod_next  = {30'd0, a} * {30'd0, b};
        // Estimated quotient, at most two below the true one.
        quot_next  = {31'd0, prod_reg[59:29]} * {31'd0, BMP_MU};
        qp_next    = {1'b0, quot_reg[61:31]} * Prime32;
        rem_next   = xlo3_reg - qp_reg;
        if (rem_reg >= Prime2x)
        begin
            res_next = BMP_RES_W'(rem_reg - Prime2x);
        end
        else if (rem_reg >= Prime32)
        begin
            res_next = BMP_RES_W'(rem_reg - Prime32);
        end
        else
        begin
            res_next = rem_reg[BMP_RES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg[0] <= op;
        for (int i = 1; i < 5; i++)
        begin
            op_reg[i] <= op_reg[i-1];
        end
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        xlo2_reg <= prod_reg[31:0];
        xlo3_reg <= xlo2_reg;
        qp_reg   <= qp_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
    end

    assign busy      = |valid_reg;
    assign res_valid = valid_reg[4];
    assign res_op    = op_reg[4];
    assign res       = res_reg;

    a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] |-> (res_reg < BMP_PRIME))
        else $error("modular product not fully reduced");

endmodule

### design/bmp_datapath.sv
// Datapath of the binomial block: operand registers, counters, exponent, result and
// output registers around the shared modular multiplier. Depends on bmp_pkg, bmp_modmul.
module bmp_datapath
    import bmp_pkg::*;
#(
    parameter int MAX_N = BMP_MAX_N
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bmp_cmd_t             cmd,
    output bmp_status_t          status,
    input  logic [BMP_IN_W-1:0]  set_size,
    input  logic [BMP_IN_W-1:0]  choose_count,
    output logic [BMP_RES_W-1:0] binomial_value
);

    localparam logic [BMP_BOUND_W-1:0] MaxBound = BMP_BOUND_W'(MAX_N);

    logic [BMP_IN_W-1:0]  n_reg;
    logic [BMP_IN_W-1:0]  n_next;
    logic [BMP_IN_W-1:0]  r_reg;
    logic [BMP_IN_W-1:0]  r_next;
    logic [BMP_IN_W-1:0]  k_reg;
    logic [BMP_IN_W-1:0]  k_next;
    logic [BMP_RES_W-1:0] num_reg;
    logic [BMP_RES_W-1:0] num_next;
    logic [BMP_RES_W-1:0] den_reg;
    logic [BMP_RES_W-1:0] den_next;
    logic [BMP_RES_W-1:0] base_reg;
    logic [BMP_RES_W-1:0] base_next;
    logic [BMP_RES_W-1:0] acc_reg;
    logic [BMP_RES_W-1:0] acc_next;
    logic [BMP_RES_W-1:0] exp_reg;
    logic [BMP_RES_W-1:0] exp_next;
    logic [BMP_RES_W-1:0] res_reg;
    logic [BMP_RES_W-1:0] res_next;
    logic [BMP_RES_W-1:0] out_reg;
    logic [BMP_RES_W-1:0] out_next;

    logic [BMP_RES_W-1:0] opa;
    logic [BMP_RES_W-1:0] opb;
    logic                 mm_busy;
    logic                 mm_valid;
    mul_op_t              mm_op;
    logic [BMP_RES_W-1:0] mm_res;

    always_comb
    begin
        case (cmd.mul_op)
            MUL_NUM:
            begin
                opa = num_reg;
                opb = BMP_RES_W'(n_reg - k_reg);
            end
            MUL_DEN:
            begin
                opa = den_reg;
                opb = BMP_RES_W'({1'b0, k_reg} + 17'd1);
            end
            MUL_ACC:
            begin
                opa = acc_reg;
                opb = base_reg;
            end
            MUL_SQR:
            begin
                opa = base_reg;
                opb = base_reg;
            end
            MUL_FIN:
            begin
                opa = num_reg;
                opb = acc_reg;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    bmp_modmul u_modmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (cmd.mul_go),
        .op        (cmd.mul_op),
        .a         (opa),
        .b         (opb),
        .busy      (mm_busy),
        .res_valid (mm_valid),
        .res_op    (mm_op),
        .res       (mm_res)
    );

    always_comb
    begin
        n_next    = cmd.load ? set_size : n_reg;
        r_next    = cmd.load ? choose_count : r_reg;
        k_next    = k_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        base_next = base_reg;
        acc_next  = acc_reg;
        exp_next  = exp_reg;
        res_next  = res_reg;
        out_next  = cmd.out_load ? res_reg : out_reg;

        if (cmd.load)
        begin
            k_next   = '0;
            num_next = BMP_RES_W'(1);
            den_next = BMP_RES_W'(1);
        end
        if (cmd.k_step)
        begin
            k_next = k_reg + BMP_IN_W'(1);
        end
        if (cmd.exp_init)
        begin
            base_next = den_reg;
            acc_next  = BMP_RES_W'(1);
            exp_next  = BMP_PRIME_M2;
        end
        if (cmd.exp_shift)
        begin
            exp_next = exp_reg >> 1;
        end
        if (cmd.res_set)
        begin
            res_next = cmd.res_one ? BMP_RES_W'(1) : '0;
        end

        // Write back the product into the register its operation code names.
        if (mm_valid)
        begin
            case (mm_op)
                MUL_NUM: num_next  = mm_res;
                MUL_DEN: den_next  = mm_res;
                MUL_ACC: acc_next  = mm_res;
                MUL_SQR: base_next = mm_res;
                MUL_FIN: res_next  = mm_res;
                default: res_next  = res_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        r_reg    <= r_next;
        k_reg    <= k_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        exp_reg  <= exp_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign status.out_of_bound = (BMP_BOUND_W'(n_reg) > MaxBound) ||
                                 (BMP_BOUND_W'(r_reg) > MaxBound);
    assign status.r_above_n    = r_reg > n_reg;
    assign status.r_zero       = r_reg == '0;
    assign status.k_last       = k_reg == (r_reg - BMP_IN_W'(1));
    assign status.exp_bit      = exp_reg[0];
    assign status.exp_last     = exp_reg[BMP_RES_W-1:1] == '0;
    assign status.mul_busy     = mm_busy;

    assign binomial_value = out_reg;

endmodule

### design/bmp_ctrl.sv
// Controller of the binomial block: one-hot state machine sequencing the product,
// exponentiation and final multiply, plus the request handshakes. Depends on bmp_pkg.
module bmp_ctrl
    import bmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  bmp_status_t status,
    output bmp_cmd_t    cmd
);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_CHECK     = 11'b000_0000_0010,
        ST_PROD_NUM  = 11'b000_0000_0100,
        ST_PROD_DEN  = 11'b000_0000_1000,
        ST_PROD_WAIT = 11'b000_0001_0000,
        ST_EXP_ACC   = 11'b000_0010_0000,
        ST_EXP_SQR   = 11'b000_0100_0000,
        ST_EXP_WAIT  = 11'b000_1000_0000,
        ST_FINAL     = 11'b001_0000_0000,
        ST_FIN_WAIT  = 11'b010_0000_0000,
        ST_DONE      = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_NUM;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.out_of_bound || status.r_above_n)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (status.r_zero)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_one = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_PROD_NUM;
                end
            end
            ST_PROD_NUM:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = MUL_NUM;
                state_next = ST_PROD_DEN;
            end
            ST_PROD_DEN:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = MUL_DEN;
                state_next = ST_PROD_WAIT;
            end
            ST_PROD_WAIT:
            begin
                if (!status.mul_busy)
                begin
                    if (status.k_last)
                    begin
                        cmd.exp_init = 1'b1;
                        state_next   = ST_EXP_ACC;
                    end
                    else
                    begin
                        cmd.k_step = 1'b1;
                        state_next = ST_PROD_NUM;
                    end
                end
            end
            ST_EXP_ACC:
            begin
                cmd.mul_go = status.exp_bit;
                cmd.mul_op = MUL_ACC;
                state_next = ST_EXP_SQR;
            end
            ST_EXP_SQR:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = MUL_SQR;
                state_next = ST_EXP_WAIT;
            end
            ST_EXP_WAIT:
            begin
                if (!status.mul_busy)
                begin
                    cmd.exp_shift = 1'b1;
                    state_next    = status.exp_last ? ST_FINAL : ST_EXP_ACC;
                end
            end
            ST_FINAL:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = MUL_FIN;
                state_next = ST_FIN_WAIT;
            end
            ST_FIN_WAIT:
            begin
                if (!status.mul_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !status.mul_busy)
        else $error("multiplier still busy while idle");

    a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output register overwritten before it was taken");

endmodule

### design/binomial_mod_prime_top.sv
// When r is 0, r exceeds n or a field is out of bound, the result is set without any multiply.
// Otherwise each of the r product steps and each of the 30 exponent steps waits out the
// 5-stage modular multiplier, which is the single arithmetic unit.
// Throughput: one request at a time; the next request is taken once the previous result has
// moved into the output register, even while that result still waits for out_ready.
// Reset: rst_n asynchronous, active low; clears the state machine and the output valid flag.
module binomial_mod_prime_top
    import bmp_pkg::*;
#(
    parameter int MAX_N = BMP_MAX_N
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BMP_IN_W-1:0]  set_size,
    input  logic [BMP_IN_W-1:0]  choose_count,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BMP_RES_W-1:0] binomial_value
);

    // The controller sequences the work and owns both handshakes; the datapath holds the
    // falling product, the factorial, the modular inverse exponentiation registers and the
    // result. Every multiply goes through one pipelined reciprocal-reduction multiplier
    // modulo 1000000007, and the controller waits for it to drain before issuing the next
    // dependent pair.
    bmp_cmd_t    cmd;
    bmp_status_t status;

    bmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The bound check against MAX_N happens in the datapath right after the request is
    // captured; an out-of-bound request simply yields zero.
    bmp_datapath #(
        .MAX_N (MAX_N)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .set_size       (set_size),
        .choose_count   (choose_count),
        .binomial_value (binomial_value)
    );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for binomial_mod_prime_top: C(n, r) mod 1000000007 per request.
// Depends on bmp_pkg and binomial_mod_prime_top; a built-in predictor supplies every expected
// value, and randomly stalling driver and receiver processes exercise both handshakes.
module tb_top;
    import bmp_pkg::*;

    localparam int TB_MAX_N     = BMP_MAX_N;
    localparam int RANDOM_ITEMS = 100;
    // Once this few requests are still waiting, neither side idles any more.
    localparam int TAIL_ITEMS   = 15;
    // The receiver refuses results for a long stretch once this many have arrived.
    localparam int HOLD_AT      = 20;
    localparam int HOLD_CYCLES  = 2500;
    localparam int DRAIN_CYCLES = 60;
    // The slowest correct run is dominated by the n = r = 65535 request;
    // this is several times the whole expected run.
    localparam int LIMIT_CYCLES = 4000000;

    typedef struct packed {
        logic [BMP_IN_W-1:0] n;
        logic [BMP_IN_W-1:0] r;
    } pair_t;

    typedef struct packed {
        logic [BMP_IN_W-1:0]  n;
        logic [BMP_IN_W-1:0]  r;
        logic [BMP_RES_W-1:0] value;
    } binomial_due_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [BMP_IN_W-1:0]  set_size = '0;
    logic [BMP_IN_W-1:0]  choose_count = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [BMP_RES_W-1:0] binomial_value;

    pair_t         pending_pairs[$];
    binomial_due_t expected_binomials[$];

    int send_gap      = 0;
    int recv_stall    = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int requests_sent = 0;
    int results_seen  = 0;
    int zero_results  = 0;
    int one_results   = 0;
    int max_r_done    = 0;
    int errors        = 0;
    int cycle_count   = 0;

    binomial_mod_prime_top #(
        .MAX_N(TB_MAX_N)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .set_size      (set_size),
        .choose_count  (choose_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .binomial_value(binomial_value)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Reset is held at the start and never asserted again.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic bit [63:0] mul_mod_p(input bit [63:0] a, input bit [63:0] b);
        return (a * b) % 64'(BMP_PRIME);
    endfunction

    // Predicts C(n, r) mod p: falling product over r!, with the factorial inverted by
    // raising it to p-2. Both operands stay below p, so every product fits in 64 bits.
    function automatic logic [BMP_RES_W-1:0] binomial_mod_p(input logic [BMP_IN_W-1:0] n,
                                                            input logic [BMP_IN_W-1:0] r);
        bit [63:0]   num;
        bit [63:0]   den;
        bit [63:0]   base;
        bit [63:0]   power;
        bit [63:0]   e;
        int unsigned k;
        if (n > TB_MAX_N || r > TB_MAX_N)
            return '0;
        if (r > n)
            return '0;
        if (r == 0)
            return BMP_RES_W'(1);
        num = 64'd1;
        den = 64'd1;
        for (k = 0; k < r; k++)
        begin
            num = mul_mod_p(num, 64'(n) - 64'(k));
            den = mul_mod_p(den, 64'(k) + 64'd1);
        end
        power = 64'd1;
        base  = den;
        e     = 64'(BMP_PRIME_M2);
        while (e != 0)
        begin
            if (e[0])
                power = mul_mod_p(power, base);
            base = mul_mod_p(base, base);
            e    = e >> 1;
        end
        return BMP_RES_W'(mul_mod_p(num, power));
    endfunction

    task automatic queue_pair(input int unsigned n, input int unsigned r);
        pair_t p;
        p.n = BMP_IN_W'(n);
        p.r = BMP_IN_W'(r);
        pending_pairs.push_back(p);
    endtask

    // Fills the request queue before reset is released: a directed opening, then a
    // random mix weighted towards short products so that the run stays affordable.
    initial
    begin : stimulus
        int          i;
        int          kind;
        int unsigned n;
        int unsigned r;
        // Choose none, at both ends of the set size.
        queue_pair(0, 0);
        queue_pair(65535, 0);
        // Choose more than set, including the widest choose count.
        queue_pair(0, 1);
        queue_pair(0, 65535);
        queue_pair(65534, 65535);
        queue_pair(5, 6);
        queue_pair('h5555, 'hAAAA);
        // Ordinary products, small and at the top of the range.
        queue_pair(1, 1);
        queue_pair(2, 1);
        queue_pair(10, 10);
        queue_pair(30, 15);
        queue_pair(65535, 1);
        queue_pair(65535, 2);
        queue_pair(32768, 3);
        queue_pair('hAAAA, 7);
        queue_pair(1000, 500);
        queue_pair(65535, 64);
        // The longest product the block can be asked for.
        queue_pair(65535, 65535);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(0, 99);
            if (i == 40 || i == 70)
            begin
                // A couple of longer products to keep the counters busy for a while.
                r = $urandom_range(1000, 3000);
                n = $urandom_range(r, 65535);
            end
            else if (kind < 55)
            begin
                r = $urandom_range(1, 64);
                n = $urandom_range(r, 65535);
            end
            else if (kind < 70)
            begin
                r = 0;
                n = $urandom_range(0, 65535);
            end
            else if (kind < 90)
            begin
                n = $urandom_range(0, 65534);
                r = $urandom_range(n + 1, 65535);
            end
            else
            begin
                n = $urandom_range(0, 40);
                r = $urandom_range(0, n);
            end
            queue_pair(n, r);
        end
    end

    // Request driver: offers the next pair once the previous one has been taken,
    // with random idle bursts between requests until the tail of the run.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        pair_t         nxt;
        binomial_due_t due;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            set_size     <= '0;
            choose_count <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                due.n     = set_size;
                due.r     = choose_count;
                due.value = binomial_mod_p(set_size, choose_count);
                expected_binomials.push_back(due);
                requests_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_pairs.size() != 0)
                begin
                    nxt = pending_pairs.pop_front();
                    in_valid     <= 1'b1;
                    set_size     <= nxt.n;
                    choose_count <= nxt.r;
                    if (pending_pairs.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 19);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: checks every accepted result against the oldest prediction and
    // drives out_ready with random stall bursts plus one long hold-off, during which
    // the block fills up and has to refuse further requests.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        binomial_due_t due;
        logic          ready_nxt;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
            hold_left  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_binomials.size() == 0)
                begin
                    $display("%0t: result %0d arrived with no request outstanding",
                             $time, binomial_value);
                    errors++;
                end
                else
                begin
                    due = expected_binomials.pop_front();
                    if (binomial_value !== due.value)
                    begin
                        $display("%0t: binomial_value for n=%0d r=%0d: expected %0d, actual %0d",
                                 $time, due.n, due.r, due.value, binomial_value);
                        errors++;
                    end
                    if (due.value == 0)
                        zero_results++;
                    if (due.value == 1)
                        one_results++;
                    if (due.r <= due.n && int'(due.r) > max_r_done)
                        max_r_done = int'(due.r);
                end
                results_seen++;
            end

            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                ready_nxt = 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                ready_nxt = 1'b0;
            end
            else if (pending_pairs.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
            begin
                // This cycle is the first of the burst.
                recv_stall = $urandom_range(1, 19) - 1;
                ready_nxt  = 1'b0;
            end
            else
            begin
                ready_nxt = 1'b1;
            end
            out_ready <= ready_nxt;
        end
    end

    // Safety net against a hung block.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timed out with %0d requests unsent and %0d results outstanding",
                 $time, pending_pairs.size(), expected_binomials.size());
        $display("tb_top NOT OK");
        $finish;
    end

    // End of run: every request sent, every result back, then a short drain to catch
    // anything the block emits unasked.
    initial
    begin
        @(posedge rst_n);
        while (pending_pairs.size() != 0 || in_valid || expected_binomials.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Checked %0d results for %0d requests: %0d zero, %0d one, r up to %0d.",
                 results_seen, requests_sent, zero_results, one_results, max_r_done);
        $display("Both sides stalled at random, with one long receiver hold-off of %0d cycles.",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
